[sv/msm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants of the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam int NODES_DEF    = 256;
  localparam int ALPHABET_DEF = 256;
  localparam int PATTERNS_DEF = 16;
  localparam int MAX_RESULTS  = 16;

  localparam logic [2:0] KIND_PSYM    = 3'd0;
  localparam logic [2:0] KIND_PEND    = 3'd1;
  localparam logic [2:0] KIND_BUILD   = 3'd2;
  localparam logic [2:0] KIND_TEXT    = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PSYM    = 3'd1,
    OP_PEND    = 3'd2,
    OP_BUILD   = 3'd3,
    OP_TEXT    = 3'd4,
    OP_RESTART = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] symbol;
    logic [3:0] pattern_id;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  match_id;
    logic [31:0] start_offset;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] symbol;
    logic       sym_ok;
    logic [3:0] pid;
    logic       pid_ok;
  } cmd_t;

endpackage

[sv/multi_pattern_string_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Multi-pattern (Aho-Corasick) string matcher with queue-style channels.
//
// Input requests (push/full, in_item) carry pattern symbols, pattern ends,
// a link build command, text symbols and a text restart. Results
// (empty/pop, out_item) are match reports, or a table-full status when a
// pattern no longer fits; the final report of a text symbol has last set.
// A two-entry command queue separates decode from the engine, and a
// two-entry result queue lets the engine run ahead of the receiver.
// A text symbol follows failure steps until a goto edge is found or the
// root is reached, then reports each tagged pattern of the node and of its
// dictionary chain. The build scans the root row of the goto table, then the
// row of each queued node in breadth-first order, following failure steps
// for each child. After reset, full stays high while the tables are swept
// to zero.
// When the receiver stops popping, the engine stalls on the full result
// queue and then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher
  import msm_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int PATTERNS = PATTERNS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic      cmd_valid, cmd_pop, busy_clear, res_push, res_full;
  cmd_t      cmd;
  out_item_t res;

  msm_front #(.ALPHABET(ALPHABET), .PATTERNS(PATTERNS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .busy_clear(busy_clear), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

  msm_engine #(.NODES(NODES), .ALPHABET(ALPHABET), .PATTERNS(PATTERNS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .busy_clear(busy_clear), .res_push(res_push), .res(res), .res_full(res_full));

  msm_outq u_outq (
    .clk(clk), .rst_n(rst_n), .res_push(res_push), .res(res), .res_full(res_full),
    .empty(empty), .pop(pop), .out_item(out_item));

endmodule

[sv/msm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/msm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_front
// Takes input requests, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module msm_front
  import msm_pkg::*;
#(
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int PATTERNS = PATTERNS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     busy_clear,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       accept, enq;

  always_comb begin
    dec.symbol = in_item.symbol;
    dec.pid    = in_item.pattern_id;
    dec.sym_ok = 9'(in_item.symbol) < 9'(ALPHABET);
    dec.pid_ok = 7'(in_item.pattern_id) < 7'(PATTERNS);
    unique case (in_item.kind)
      KIND_PSYM:    dec.op = OP_PSYM;
      KIND_PEND:    dec.op = OP_PEND;
      KIND_BUILD:   dec.op = OP_BUILD;
      KIND_TEXT:    dec.op = OP_TEXT;
      KIND_RESTART: dec.op = OP_RESTART;
      default:      dec.op = OP_NONE;
    endcase
  end

  assign full   = (cnt_r == 2'd2) || busy_clear;
  assign accept = push && !full;
  // drop unused kinds and pattern symbols outside the alphabet here
  assign enq    = accept && (dec.op != OP_NONE) && !(dec.op == OP_PSYM && !dec.sym_ok);

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (enq) begin
      wp_nxt = !wp_r;
    end
    if (cmd_pop && cmd_valid) begin
      rp_nxt = !rp_r;
    end
    cnt_nxt = cnt_r + 2'(enq) - 2'(cmd_pop && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wp_r] <= dec;
    end
  end

endmodule

[sv/msm_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_outq
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module msm_outq
  import msm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_push,
  input  out_item_t res,
  output logic      res_full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  out_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       enq, deq;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign enq      = res_push && !res_full;
  assign deq      = pop && !empty;
  assign out_item = mem_r[rp_r];
  assign cnt_nxt  = cnt_r + 2'(enq) - 2'(deq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (enq) begin
        wp_r <= !wp_r;
      end
      if (deq) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wp_r] <= res;
    end
  end

endmodule

[sv/msm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_engine
// Back end: trie insertion, breadth-first link build and text matching.
// ----------------------------------------------------------------------------
module msm_engine
  import msm_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int PATTERNS = PATTERNS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      busy_clear,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  localparam int NW  = $clog2(NODES);
  localparam int AW  = $clog2(ALPHABET);
  localparam int GW  = NW + AW;
  localparam int IDW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int RW  = $clog2(MAX_RESULTS + 1);
  localparam logic [AW-1:0] ALAST = AW'(ALPHABET - 1);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_PCHK    = 16'h0004,
    S_PEND    = 16'h0008,
    S_TCHK    = 16'h0010,
    S_TFAIL   = 16'h0020,
    S_TREP_LD = 16'h0040,
    S_TREP    = 16'h0080,
    S_BROOT   = 16'h0100,
    S_BNEXTP  = 16'h0200,
    S_BPLD    = 16'h0400,
    S_BPFL    = 16'h0800,
    S_BCH     = 16'h1000,
    S_BFCHK   = 16'h2000,
    S_BFFL    = 16'h4000,
    S_BD      = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [GW-1:0]       clr_r, clr_nxt;
  logic [NW:0]         count_r, count_nxt;
  logic [NW-1:0]       cursor_r, cursor_nxt;
  logic [NW-1:0]       len_r, len_nxt;
  logic                ovf_r, ovf_nxt;
  logic [NW-1:0]       mnode_r, mnode_nxt;
  logic [31:0]         pos_r, pos_nxt;
  logic [AW-1:0]       sym_r, sym_nxt;
  logic [3:0]          pid_r, pid_nxt;
  logic [NW-1:0]       node_r, node_nxt;
  logic [PATTERNS-1:0] set_r, set_nxt;
  logic [NW-1:0]       dlink_r, dlink_nxt;
  logic [RW-1:0]       n_r, n_nxt;
  logic [AW-1:0]       c_r, c_nxt;
  logic [NW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0]       p_r, p_nxt, fp_r, fp_nxt, ch_r, ch_nxt;
  logic [NW-1:0]       f_r, f_nxt, nf_r, nf_nxt;
  logic [NW-1:0]       plen_r [PATTERNS];
  logic                plen_we;

  logic                g_re, g_we;
  logic [GW-1:0]       g_ra, g_wa;
  logic [NW-1:0]       g_q, g_wd;
  logic                f_re, f_we, d_re, d_we, m_re, m_we, q_re, q_we;
  logic [NW-1:0]       f_ra, f_wa, f_q, f_wd;
  logic [NW-1:0]       d_ra, d_wa, d_q, d_wd;
  logic [NW-1:0]       m_ra, m_wa;
  logic [PATTERNS-1:0] m_q, m_wd;
  logic [NW-1:0]       q_ra, q_wa, q_q, q_wd;

  logic [IDW-1:0]      low_id;
  logic [PATTERNS-1:0] rest;
  logic                rep_last;

  msm_ram #(.WIDTH(NW), .DEPTH(1 << GW)) u_goto (
    .clk(clk), .rd_en(g_re), .rd_addr(g_ra), .rd_data(g_q),
    .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd));
  msm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
    .clk(clk), .rd_en(f_re), .rd_addr(f_ra), .rd_data(f_q),
    .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd));
  msm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_dict (
    .clk(clk), .rd_en(d_re), .rd_addr(d_ra), .rd_data(d_q),
    .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd));
  msm_ram #(.WIDTH(PATTERNS), .DEPTH(NODES)) u_match (
    .clk(clk), .rd_en(m_re), .rd_addr(m_ra), .rd_data(m_q),
    .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd));
  msm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk(clk), .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_q),
    .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd));

  // lowest pending id of the node being reported
  always_comb begin
    low_id = '0;
    for (int i = PATTERNS - 1; i >= 0; i--) begin
      if (set_r[i]) begin
        low_id = IDW'(i);
      end
    end
  end

  assign rest     = set_r & (set_r - PATTERNS'(1));
  assign rep_last = (n_r == RW'(MAX_RESULTS - 1)) || ((rest == '0) && (dlink_r == '0));

  assign busy_clear = (state_r == S_CLEAR);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    mnode_nxt  = mnode_r;
    pos_nxt    = pos_r;
    sym_nxt    = sym_r;
    pid_nxt    = pid_r;
    node_nxt   = node_r;
    set_nxt    = set_r;
    dlink_nxt  = dlink_r;
    n_nxt      = n_r;
    c_nxt      = c_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    p_nxt      = p_r;
    fp_nxt     = fp_r;
    ch_nxt     = ch_r;
    f_nxt      = f_r;
    nf_nxt     = nf_r;
    plen_we    = 1'b0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res.status       = STATUS_MATCH;
    res.match_id     = 4'(low_id);
    res.start_offset = pos_r - 32'(plen_r[low_id]) + 32'd1;
    res.last         = rep_last;
    g_re = 1'b0; g_ra = '0; g_we = 1'b0; g_wa = '0; g_wd = '0;
    f_re = 1'b0; f_ra = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
    d_re = 1'b0; d_ra = '0; d_we = 1'b0; d_wa = '0; d_wd = '0;
    m_re = 1'b0; m_ra = '0; m_we = 1'b0; m_wa = '0; m_wd = '0;
    q_re = 1'b0; q_ra = '0; q_we = 1'b0; q_wa = '0; q_wd = '0;

    unique case (state_r)
      S_CLEAR: begin
        g_we = 1'b1; g_wa = clr_r;
        f_we = 1'b1; f_wa = clr_r[NW-1:0];
        d_we = 1'b1; d_wa = clr_r[NW-1:0];
        m_we = 1'b1; m_wa = clr_r[NW-1:0];
        clr_nxt = clr_r + GW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          sym_nxt = cmd.symbol[AW-1:0];
          pid_nxt = cmd.pid;
          unique case (cmd.op)
            OP_PSYM: begin
              if (!ovf_r) begin
                g_re = 1'b1; g_ra = {cursor_r, cmd.symbol[AW-1:0]};
                state_nxt = S_PCHK;
              end
            end
            OP_PEND: begin
              if (!ovf_r && cursor_r != '0 && cmd.pid_ok) begin
                m_re = 1'b1; m_ra = cursor_r;
                state_nxt = S_PEND;
              end else begin
                cursor_nxt = '0;
                len_nxt    = '0;
                ovf_nxt    = 1'b0;
              end
            end
            OP_BUILD: begin
              c_nxt    = '0;
              head_nxt = '0;
              tail_nxt = '0;
              g_re = 1'b1; g_ra = '0;
              state_nxt = S_BROOT;
            end
            OP_TEXT: begin
              if (cmd.sym_ok) begin
                node_nxt = mnode_r;
                g_re = 1'b1; g_ra = {mnode_r, cmd.symbol[AW-1:0]};
                state_nxt = S_TCHK;
              end else begin
                mnode_nxt = '0;
                pos_nxt   = pos_r + 32'd1;
              end
            end
            OP_RESTART: begin
              mnode_nxt = '0;
              pos_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PEND: begin
        m_we = 1'b1; m_wa = cursor_r;
        m_wd = m_q | (PATTERNS'(1) << pid_r);
        plen_we    = 1'b1;
        cursor_nxt = '0;
        len_nxt    = '0;
        ovf_nxt    = 1'b0;
        state_nxt  = S_IDLE;
      end
      S_PCHK: begin
        if (g_q != '0) begin
          cursor_nxt = g_q;
          len_nxt    = len_r + NW'(1);
          state_nxt  = S_IDLE;
        end else if (count_r == (NW+1)'(NODES)) begin
          res.status       = STATUS_FULL;
          res.match_id     = '0;
          res.start_offset = '0;
          res.last         = 1'b1;
          // hold until the result queue has room
          if (!res_full) begin
            res_push  = 1'b1;
            ovf_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          g_we = 1'b1; g_wa = {cursor_r, sym_r}; g_wd = count_r[NW-1:0];
          f_we = 1'b1; f_wa = count_r[NW-1:0];
          d_we = 1'b1; d_wa = count_r[NW-1:0];
          m_we = 1'b1; m_wa = count_r[NW-1:0];
          cursor_nxt = count_r[NW-1:0];
          count_nxt  = count_r + (NW+1)'(1);
          len_nxt    = len_r + NW'(1);
          state_nxt  = S_IDLE;
        end
      end
      S_TCHK: begin
        if (g_q != '0 || node_r == '0) begin
          mnode_nxt = g_q;
          m_re = 1'b1; m_ra = g_q;
          d_re = 1'b1; d_ra = g_q;
          n_nxt     = '0;
          state_nxt = S_TREP_LD;
        end else begin
          f_re = 1'b1; f_ra = node_r;
          state_nxt = S_TFAIL;
        end
      end
      S_TFAIL: begin
        node_nxt = f_q;
        g_re = 1'b1; g_ra = {f_q, sym_r};
        state_nxt = S_TCHK;
      end
      S_TREP_LD: begin
        set_nxt   = m_q;
        dlink_nxt = d_q;
        state_nxt = S_TREP;
      end
      S_TREP: begin
        if (set_r != '0) begin
          if (!res_full) begin
            res_push = 1'b1;
            set_nxt  = rest;
            n_nxt    = n_r + RW'(1);
            if (rep_last) begin
              pos_nxt   = pos_r + 32'd1;
              state_nxt = S_IDLE;
            end
          end
        end else if (dlink_r != '0) begin
          m_re = 1'b1; m_ra = dlink_r;
          d_re = 1'b1; d_ra = dlink_r;
          state_nxt = S_TREP_LD;
        end else begin
          pos_nxt   = pos_r + 32'd1;
          state_nxt = S_IDLE;
        end
      end
      S_BROOT: begin
        if (g_q != '0) begin
          f_we = 1'b1; f_wa = g_q;
          d_we = 1'b1; d_wa = g_q;
          q_we = 1'b1; q_wa = tail_r; q_wd = g_q;
          tail_nxt = tail_r + NW'(1);
        end
        if (c_r == ALAST) begin
          state_nxt = S_BNEXTP;
        end else begin
          c_nxt = c_r + AW'(1);
          g_re = 1'b1; g_ra = {NW'(0), c_r + AW'(1)};
        end
      end
      S_BNEXTP: begin
        if (head_r == tail_r) begin
          mnode_nxt = '0;
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          q_re = 1'b1; q_ra = head_r;
          state_nxt = S_BPLD;
        end
      end
      S_BPLD: begin
        p_nxt    = q_q;
        head_nxt = head_r + NW'(1);
        f_re = 1'b1; f_ra = q_q;
        state_nxt = S_BPFL;
      end
      S_BPFL: begin
        fp_nxt = f_q;
        c_nxt  = '0;
        g_re = 1'b1; g_ra = {p_r, AW'(0)};
        state_nxt = S_BCH;
      end
      S_BCH: begin
        if (g_q == '0) begin
          if (c_r == ALAST) begin
            state_nxt = S_BNEXTP;
          end else begin
            c_nxt = c_r + AW'(1);
            g_re = 1'b1; g_ra = {p_r, c_r + AW'(1)};
          end
        end else begin
          ch_nxt = g_q;
          f_nxt  = fp_r;
          g_re = 1'b1; g_ra = {fp_r, c_r};
          state_nxt = S_BFCHK;
        end
      end
      S_BFCHK: begin
        if (f_r != '0 && g_q == '0) begin
          f_re = 1'b1; f_ra = f_r;
          state_nxt = S_BFFL;
        end else begin
          f_we = 1'b1; f_wa = ch_r; f_wd = g_q;
          nf_nxt = g_q;
          m_re = 1'b1; m_ra = g_q;
          d_re = 1'b1; d_ra = g_q;
          state_nxt = S_BD;
        end
      end
      S_BFFL: begin
        f_nxt = f_q;
        g_re = 1'b1; g_ra = {f_q, c_r};
        state_nxt = S_BFCHK;
      end
      S_BD: begin
        d_we = 1'b1; d_wa = ch_r;
        d_wd = (m_q != '0) ? nf_r : d_q;
        q_we = 1'b1; q_wa = tail_r; q_wd = ch_r;
        tail_nxt = tail_r + NW'(1);
        if (c_r == ALAST) begin
          state_nxt = S_BNEXTP;
        end else begin
          c_nxt = c_r + AW'(1);
          g_re = 1'b1; g_ra = {p_r, c_r + AW'(1)};
          state_nxt = S_BCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      count_r  <= (NW+1)'(1);
      cursor_r <= '0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      mnode_r  <= '0;
      pos_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      c_r      <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      mnode_r  <= mnode_nxt;
      pos_r    <= pos_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      c_r      <= c_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    pid_r   <= pid_nxt;
    node_r  <= node_nxt;
    set_r   <= set_nxt;
    dlink_r <= dlink_nxt;
    p_r     <= p_nxt;
    fp_r    <= fp_nxt;
    ch_r    <= ch_nxt;
    f_r     <= f_nxt;
    nf_r    <= nf_nxt;
    if (plen_we) begin
      plen_r[IDW'(pid_r)] <= len_r;
    end
  end

endmodule
